@@ hdl/dfs_pkg.sv @@
// Package: shared types and constants of the delimiter field splitter.
package dfs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;
    localparam int MATCH_W    = 3;
    localparam int FCNT_W     = 8;

    localparam logic [CFG_DATA_W-1:0] DELIM_RESET = 64'd44;
    localparam logic [LEN_W-1:0]      LEN_RESET   = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_BYTES = 2'd0,
        CFG_DELIM_LEN   = 2'd1,
        CFG_MAX_FIELDS  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_EOS  = 1'b1
    } t_op;

    // One queued job: emit nbytes window bytes, then an optional field end.
    typedef struct packed {
        logic [MATCH_W-1:0] match;
        logic [7:0]         data;
        logic [LEN_W-1:0]   nbytes;
        logic               fe;
        logic               se;
    } t_cmd;

endpackage

@@ hdl/dfs_if.sv @@
// Interfaces: input word, result word and configuration write channels.
interface dfs_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_byte;
    modport source (output valid, output op, output in_byte, input ready);
    modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface dfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       field_end;
    logic       string_end;
    logic       last;
    modport source (output valid, output out_byte, output has_byte, output field_end,
                    output string_end, output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input field_end,
                    input string_end, input last, output ready);
endinterface

interface dfs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [dfs_pkg::CFG_IDX_W-1:0]  index;
    logic [dfs_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/dfs_front.sv @@
// Front end: accepts words, tracks the partial match and field count, issues jobs.
module dfs_front #(
    parameter int MAX_DELIM_LEN = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dfs_in_if.sink                              i_in,
    input  logic [MAX_DELIM_LEN-1:0][7:0]       i_delim,
    input  logic [dfs_pkg::LEN_W-1:0]           i_len,
    input  logic [dfs_pkg::FCNT_W-1:0]          i_max_fields,
    input  logic                                i_full,
    output logic                                o_push,
    output dfs_pkg::t_cmd                       o_cmd
);
    import dfs_pkg::*;

    localparam int MW = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

    logic [MATCH_W-1:0]             r_match, n_match;
    logic [FCNT_W-1:0]              r_fcnt, n_fcnt;
    logic [LEN_W-1:0]               len_eff;
    logic [MAX_DELIM_LEN-1:0][7:0]  win;
    logic [LEN_W-1:0]               k_best;
    logic                           limit;
    logic                           fire;

    assign i_in.ready = !i_full;
    assign fire       = i_in.valid && !i_full;

    always_comb begin
        if (i_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (i_len > LEN_W'(MAX_DELIM_LEN)) begin
            len_eff = LEN_W'(MAX_DELIM_LEN);
        end else begin
            len_eff = i_len;
        end
    end

    assign limit = (i_max_fields != '0) &&
                   (({1'b0, r_fcnt} + 9'd1) >= {1'b0, i_max_fields});

    // Window: pending delimiter prefix followed by the new byte.
    always_comb begin
        for (int i = 0; i < MAX_DELIM_LEN; i++) begin
            if (i < int'(r_match)) begin
                win[i] = i_delim[i];
            end else begin
                win[i] = i_in.in_byte;
            end
        end
    end

    // Longest suffix of the window that is a delimiter prefix.
    always_comb begin
        logic          ok;
        int            idx;
        logic [MW-1:0] wi;
        k_best = '0;
        for (int k = 1; k <= MAX_DELIM_LEN; k++) begin
            ok = (k <= int'(len_eff)) && (k <= int'(r_match) + 1);
            for (int j = 0; j < k; j++) begin
                idx = int'(r_match) + 1 - k + j;
                wi  = MW'(idx);
                if (ok && (win[wi] != i_delim[j])) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                k_best = LEN_W'(k);
            end
        end
    end

    always_comb begin
        n_match      = r_match;
        n_fcnt       = r_fcnt;
        o_cmd.match  = r_match;
        o_cmd.data   = i_in.in_byte;
        o_cmd.nbytes = '0;
        o_cmd.fe     = 1'b0;
        o_cmd.se     = 1'b0;
        if (t_op'(i_in.op) == OP_EOS) begin
            o_cmd.nbytes = LEN_W'(r_match);
            o_cmd.fe     = 1'b1;
            o_cmd.se     = 1'b1;
            n_match      = '0;
            n_fcnt       = '0;
        end else if (limit) begin
            o_cmd.nbytes = LEN_W'(r_match) + LEN_W'(1);
            n_match      = '0;
        end else begin
            o_cmd.nbytes = LEN_W'(r_match) + LEN_W'(1) - k_best;
            if (k_best == len_eff) begin
                o_cmd.fe = 1'b1;
                n_match  = '0;
                if (r_fcnt != '1) begin
                    n_fcnt = r_fcnt + FCNT_W'(1);
                end
            end else begin
                n_match = MATCH_W'(k_best);
            end
        end
    end

    assign o_push = fire && ((o_cmd.nbytes != '0) || o_cmd.fe);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
            r_fcnt  <= '0;
        end else if (fire) begin
            r_match <= n_match;
            r_fcnt  <= n_fcnt;
        end
    end

endmodule

@@ hdl/dfs_fifo.sv @@
// Job queue between front end and back end.
module dfs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dfs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output dfs_pkg::t_cmd o_cmd
);
    import dfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/dfs_back.sv @@
// Back end: walks head job; one result word per cycle unless stalled.
module dfs_back #(
    parameter int MAX_DELIM_LEN = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [MAX_DELIM_LEN-1:0][7:0] i_delim,
    input  logic                          i_empty,
    input  dfs_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    dfs_out_if.source                     o_out
);
    import dfs_pkg::*;

    localparam int MW = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

    logic [LEN_W-1:0] r_idx;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_hb, r_fe, r_se, r_last;
    logic             load, is_byte, is_last;
    logic [LEN_W:0]   total;
    logic [7:0]       cur_byte;

    assign load    = !i_empty && (!r_valid || o_out.ready);
    assign total   = {1'b0, i_cmd.nbytes} + (LEN_W+1)'(i_cmd.fe);
    assign is_byte = (r_idx < i_cmd.nbytes);
    assign is_last = ({1'b0, r_idx} + (LEN_W+1)'(1)) == total;
    assign o_pop   = load && is_last;

    always_comb begin
        if (r_idx < LEN_W'(i_cmd.match)) begin
            cur_byte = i_delim[r_idx[MW-1:0]];
        end else begin
            cur_byte = i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + LEN_W'(1);
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= is_byte ? cur_byte : 8'd0;
            r_hb   <= is_byte;
            r_fe   <= !is_byte;
            r_se   <= !is_byte && i_cmd.se;
            r_last <= is_last;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.has_byte   = r_hb;
    assign o_out.field_end  = r_fe;
    assign o_out.string_end = r_se;
    assign o_out.last       = r_last;

endmodule

@@ hdl/delimiter_field_splitter.sv @@
// Top level: splits a byte stream into fields at a configurable delimiter.
//
// Channels: i_in takes one word per string byte (op = data) or an end-of-string
// marker (op = end). o_out gives one result word per field byte or field end;
// the last word caused by an input carries last. i_cfg writes delim_bytes (0),
// delim_len (1) and max_fields (2); it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Throughput: one input word per cycle while the job queue has room; the output
// side drives one result word per cycle from the head job while the receiver is
// ready. Bytes held as a partial match come out later, so each byte that is
// not part of a completed delimiter leaves exactly once. Path: a word accepted
// with an empty queue is written into the queue, then into the output register.
// A word that causes n result words holds the back end until all n are taken.
// Reset: delimiter is a comma, length 1, no field limit, match length and field
// count cleared, queue emptied.
// A stalled receiver holds the output register; the front keeps accepting until
// the FIFO_DEPTH-entry queue fills, then drops i_in.ready.
module delimiter_field_splitter #(
    parameter int MAX_DELIM_LEN = 8,
    parameter int FIFO_DEPTH    = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfs_in_if.sink    i_in,
    dfs_cfg_if.sink   i_cfg,
    dfs_out_if.source o_out
);
    import dfs_pkg::*;

    logic [MAX_DELIM_LEN-1:0][7:0] r_delim;
    logic [LEN_W-1:0]              r_len;
    logic [FCNT_W-1:0]             r_max_fields;
    logic                          cfg_fire;
    logic                          push, pop, full, empty;
    t_cmd                          front_cmd, head_cmd;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim      <= DELIM_RESET[8*MAX_DELIM_LEN-1:0];
            r_len        <= LEN_RESET;
            r_max_fields <= '0;
        end else if (cfg_fire) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_DELIM_BYTES: r_delim      <= i_cfg.data[8*MAX_DELIM_LEN-1:0];
                CFG_DELIM_LEN:   r_len        <= i_cfg.data[LEN_W-1:0];
                CFG_MAX_FIELDS:  r_max_fields <= i_cfg.data[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    dfs_front #(.MAX_DELIM_LEN(MAX_DELIM_LEN)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_delim      (r_delim),
        .i_len        (r_len),
        .i_max_fields (r_max_fields),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    dfs_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    dfs_back #(.MAX_DELIM_LEN(MAX_DELIM_LEN)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_delim (r_delim),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("job popped from empty queue");

    a_se_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> (o_out.field_end && o_out.last))
        else $error("string end without field end and last");

    a_word_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.has_byte != o_out.field_end))
        else $error("result word is neither byte nor field end");

endmodule

@@ sim/delimiter_field_splitter_tb.sv @@
`timescale 1ns / 100ps
// Testbench: drives byte strings into the delimiter field splitter and checks every result word.
module delimiter_field_splitter_tb;
    import dfs_pkg::*;

    localparam int MAX_LEN        = 8;
    localparam int IDLE_PAD       = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 150;
    localparam logic [7:0] COMMA  = 8'h2C;

    typedef struct {
        t_op        op;
        logic [7:0] data;
    } t_stream_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       field_end;
        logic       string_end;
        logic       last;
    } t_field_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid  = 1'b0;
    t_op        in_op     = OP_DATA;
    logic [7:0] in_data   = 8'h00;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    t_cfg_idx   cfg_index = CFG_DELIM_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dfs_in_if  in_ch();
    dfs_out_if out_ch();
    dfs_cfg_if cfg_ch();

    assign in_ch.valid   = in_valid;
    assign in_ch.op      = in_op;
    assign in_ch.in_byte = in_data;
    assign out_ch.ready  = out_ready;
    assign cfg_ch.valid  = cfg_valid;
    assign cfg_ch.index  = cfg_index;
    assign cfg_ch.data   = cfg_data;

    delimiter_field_splitter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [63:0] delim_bytes_r = DELIM_RESET;
    logic [3:0]  delim_len_r   = LEN_RESET;
    logic [7:0]  max_fields_r  = 8'd0;
    int match_len     = 0;
    int fields_closed = 0;

    t_stream_word  byte_stream[$];
    t_field_result field_results[$];
    int words_total    = 0;
    int words_accepted = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    logic [5:0]  stall_step    = '0;
    logic [31:0] ready_pattern = '1;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int active_len();
        if (delim_len_r == 4'd0)
            return 1;
        if (delim_len_r > MAX_LEN)
            return MAX_LEN;
        return int'(delim_len_r);
    endfunction

    function automatic logic [7:0] delim_byte(input int i);
        return delim_bytes_r[8*i +: 8];
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        t_field_result r;
        r = {b, 1'b1, 1'b0, 1'b0, 1'b0};
        field_results.insert(field_results.size(), r);
    endfunction

    function automatic void emit_end(input logic closes_string);
        t_field_result r;
        r = {8'h00, 1'b0, 1'b1, closes_string, 1'b0};
        field_results.insert(field_results.size(), r);
    endfunction

    // expected result words for one accepted input word
    task automatic split_word(input t_op op, input logic [7:0] b);
        logic [7:0] win [0:MAX_LEN-1];
        int len, m, wlen, k, n0, i, j;
        bit hit;
        len  = active_len();
        m    = match_len;
        n0   = field_results.size();
        for (i = 0; i < m; i++)
            win[i] = delim_byte(i);
        win[m] = b;
        wlen = m + 1;
        if (op == OP_EOS) begin
            for (i = 0; i < m; i++)
                emit_byte(win[i]);
            emit_end(1'b1);
            match_len     = 0;
            fields_closed = 0;
        end else if (max_fields_r != 0 && fields_closed + 1 >= max_fields_r) begin
            for (i = 0; i < wlen; i++)
                emit_byte(win[i]);
            match_len = 0;
        end else begin
            for (k = (wlen < len) ? wlen : len; k > 0; k--) begin
                hit = 1'b1;
                for (j = 0; j < k; j++)
                    if (win[wlen-k+j] != delim_byte(j))
                        hit = 1'b0;
                if (hit)
                    break;
            end
            for (i = 0; i < wlen - k; i++)
                emit_byte(win[i]);
            if (k == len) begin
                emit_end(1'b0);
                if (fields_closed < 255)
                    fields_closed++;
                match_len = 0;
            end else begin
                match_len = k;
            end
        end
        if (field_results.size() > n0)
            field_results[field_results.size() - 1].last = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_data(input logic [7:0] b);
        t_stream_word w;
        w.op   = OP_DATA;
        w.data = b;
        byte_stream.insert(byte_stream.size(), w);
        words_total++;
    endfunction

    function automatic void push_eos();
        t_stream_word w;
        w.op   = OP_EOS;
        w.data = 8'($urandom);
        byte_stream.insert(byte_stream.size(), w);
        words_total++;
    endfunction

    // input driver: bursts of random length, random gaps
    always @(posedge clk) begin
        t_stream_word w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ch.ready) begin
                split_word(in_op, in_data);
                words_accepted++;
            end
            if (!in_valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_stream.size() > 0) begin
                    w = byte_stream.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= w.op;
                    in_data  <= w.data;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk) begin
        t_field_result got, want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ready) begin
                got = {out_ch.out_byte, out_ch.has_byte, out_ch.field_end,
                       out_ch.string_end, out_ch.last};
                if (field_results.size() == 0) begin
                    report_mismatch("unexpected word", got.out_byte, 8'h00);
                end else begin
                    want = field_results.pop_front();
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", got.out_byte, want.out_byte);
                    if (got.has_byte != want.has_byte)
                        report_mismatch("has_byte", 8'(got.has_byte), 8'(want.has_byte));
                    if (got.field_end != want.field_end)
                        report_mismatch("field_end", 8'(got.field_end), 8'(want.field_end));
                    if (got.string_end != want.string_end)
                        report_mismatch("string_end", 8'(got.string_end),
                                        8'(want.string_end));
                    if (got.last != want.last)
                        report_mismatch("last", 8'(got.last), 8'(want.last));
                end
            end
            if (stall_step == 6'd0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = $urandom;
                    2: ready_pattern = $urandom | $urandom;
                    default: ready_pattern = $urandom & $urandom;
                endcase
                if (ready_pattern == '0)
                    ready_pattern = 32'd1;
            end
            out_ready <= ready_pattern[stall_step[4:0]];
            stall_step = stall_step + 6'd1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ch.ready) || (out_ch.valid && out_ready) ||
            (cfg_valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("delimiter_field_splitter_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DELIM_BYTES: delim_bytes_r = value;
            CFG_DELIM_LEN:   delim_len_r   = value[3:0];
            CFG_MAX_FIELDS:  max_fields_r  = value[7:0];
            default: ;
        endcase
    endtask

    // wait until every word is taken and every result seen, then let the block settle
    task automatic drain();
        do @(posedge clk); while (words_accepted != words_total || field_results.size() != 0);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic pick_config(input int phase);
        logic [63:0] value;
        logic [7:0]  sym_a, sym_b;
        int i;
        if (phase < 3 || $urandom_range(0, 2) != 0) begin
            sym_a = 8'($urandom);
            sym_b = 8'($urandom);
            case ($urandom_range(0, 4))
                0: value = {$urandom, $urandom};
                1: value = '0;
                2: value = '1;
                default: begin
                    for (i = 0; i < MAX_LEN; i++)
                        value[8*i +: 8] = ($urandom_range(0, 1) == 0) ? sym_a : sym_b;
                end
            endcase
            write_reg(CFG_DELIM_BYTES, value);
        end
        if (phase < 3 || $urandom_range(0, 2) != 0) begin
            value = {$urandom, $urandom};
            case ((phase < 2) ? phase : $urandom_range(2, 7))
                0: value[3:0] = 4'd0;
                1: value[3:0] = 4'd15;
                2: value[3:0] = 4'd8;
                3: value[3:0] = 4'd9;
                default: value[3:0] = 4'($urandom_range(1, MAX_LEN));
            endcase
            write_reg(CFG_DELIM_LEN, value);
        end
        if (phase < 3 || $urandom_range(0, 2) != 0) begin
            value = {$urandom, $urandom};
            case ((phase == 2) ? 0 : $urandom_range(1, 6))
                0: value[7:0] = 8'd1;
                1: value[7:0] = 8'd255;
                2, 3: value[7:0] = 8'd0;
                default: value[7:0] = 8'($urandom_range(2, 5));
            endcase
            write_reg(CFG_MAX_FIELDS, value);
        end
    endtask

    // mostly delimiter pieces and delimiter bytes, some noise and string ends
    task automatic fill_phase(input int n);
        int start, len, k, i;
        start = words_total;
        len   = active_len();
        while (words_total - start < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    for (i = 0; i < len; i++)
                        push_data(delim_byte(i));
                end
                2: begin
                    k = $urandom_range(1, len);
                    for (i = 0; i < k; i++)
                        push_data(delim_byte(i));
                end
                3, 4, 5, 6: push_data(delim_byte($urandom_range(0, len - 1)));
                7, 8: push_data(8'($urandom));
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        push_eos();
                    else
                        push_data(8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        int phase, start;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty string, then empty fields, extreme bytes and a trailing delimiter
        push_eos();
        push_data(8'h00);
        push_data(COMMA);
        push_data(COMMA);
        push_data(8'hFF);
        push_data(COMMA);
        push_eos();
        drain();

        // multibyte delimiter with fallback, then a partial match flushed at string end
        write_reg(CFG_DELIM_BYTES, 64'hFFFF_FFFF_FF62_6161);
        write_reg(CFG_DELIM_LEN, 64'h0000_0000_0000_0003);
        push_data("a");
        push_data("a");
        push_data("a");
        push_data("b");
        push_data("a");
        push_data("a");
        push_eos();
        drain();

        // field limit of two
        write_reg(CFG_DELIM_BYTES, {56'h0, COMMA});
        write_reg(CFG_DELIM_LEN, 64'hFFFF_FFFF_FFFF_FFF1);
        write_reg(CFG_MAX_FIELDS, 64'hA5A5_A5A5_A5A5_A502);
        push_data(COMMA);
        push_data(COMMA);
        push_data("x");
        push_eos();
        drain();

        // field count saturates, then a limit of 255 applies mid-string
        write_reg(CFG_MAX_FIELDS, 64'h5A5A_5A5A_5A5A_5A00);
        repeat (256) push_data(COMMA);
        drain();
        write_reg(CFG_MAX_FIELDS, 64'h0000_0000_0000_00FF);
        push_data(COMMA);
        push_data("x");
        push_eos();
        drain();

        // random phases; strings may stay open across a register write
        phase = 0;
        start = words_total;
        while (words_total - start < RANDOM_WORDS) begin
            pick_config(phase);
            fill_phase($urandom_range(10, 45));
            if ($urandom_range(0, 3) != 0)
                push_eos();
            drain();
            phase++;
        end
        push_eos();
        drain();

        if (mismatch_count == 0)
            $display("delimiter_field_splitter_tb: clean");
        else
            $display("delimiter_field_splitter_tb: errors");
        $finish;
    end

endmodule
